/* hdl/coefficient_compress_pack_unit_defines.svh */
// Assertion macros shared by the coefficient compress and pack unit.
`ifndef COEFFICIENT_COMPRESS_PACK_UNIT_DEFINES_SVH
`define COEFFICIENT_COMPRESS_PACK_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define CCP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccp assertion failed");

// Check that cons holds in the cycle after ante.
`define CCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccp assertion failed");

`endif

/* hdl/ccp_pkg.sv */
// Package with shared constants, types and state codes of the compress and pack unit.
`timescale 1ns / 1ps
package ccp_pkg;

    localparam int COEFF_BITS = 12;
    localparam int MOD_BITS   = 13;
    localparam int D_BITS     = 4;
    localparam int DIV_W      = 2 * COEFF_BITS + 1;
    localparam int STEP_W     = $clog2(DIV_W);
    localparam int ACC_W      = 22;
    localparam int CNT_W      = 5;
    localparam int VAL_W      = 16;

    localparam logic REG_MODULUS = 1'b0;
    localparam logic REG_BITS    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MERGE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic merge;
        logic emit_byte;
        logic emit_flush;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic count_ge8;
        logic count_zero;
        logic last;
        logic out_free;
    } status_t;

endpackage

/* hdl/ccp_datapath.sv */
// Datapath: configuration, serial divider, bit accumulator and output register.
`timescale 1ns / 1ps
module ccp_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [12:0]          cfg_data,
    input  logic [15:0]          s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast,
    input  ccp_pkg::cmd_t        cmd,
    output ccp_pkg::status_t     status
);

    logic [ccp_pkg::MOD_BITS-1:0]   modulus_reg;
    logic [ccp_pkg::D_BITS-1:0]     bits_reg;
    logic [ccp_pkg::COEFF_BITS-1:0] x_reg;
    logic                           last_reg;
    logic                           need_div_reg;
    logic [ccp_pkg::DIV_W-1:0]      dividend_reg;
    logic [ccp_pkg::MOD_BITS-1:0]   rem_reg;
    logic [ccp_pkg::DIV_W-1:0]      quot_reg;
    logic [ccp_pkg::STEP_W-1:0]     step_reg;
    logic [ccp_pkg::ACC_W-1:0]      acc_reg;
    logic [ccp_pkg::ACC_W-1:0]      acc_next;
    logic [ccp_pkg::CNT_W-1:0]      count_reg;
    logic [ccp_pkg::CNT_W-1:0]      count_next;
    logic [7:0]                     out_data_reg;
    logic                           out_last_reg;
    logic                           out_valid_reg;

    logic [16:0]                    pow2;
    logic                           need_div_in;
    logic [ccp_pkg::DIV_W-1:0]      dividend_init;
    logic [ccp_pkg::MOD_BITS:0]     rem_shift;
    logic                           rem_ge;
    logic [ccp_pkg::VAL_W-1:0]      dmask;
    logic [ccp_pkg::VAL_W-1:0]      val;
    logic [6:0]                     pend;
    logic [ccp_pkg::CNT_W-1:0]      byte_shift;
    logic [7:0]                     byte_val;
    logic [7:0]                     flush_val;

    assign pow2          = 17'(1) << bits_reg;
    assign need_div_in   = pow2 < {4'b0, modulus_reg};
    assign dividend_init = ({13'b0, s_tdata[ccp_pkg::COEFF_BITS-1:0]} << bits_reg)
                         + ccp_pkg::DIV_W'(modulus_reg >> 1);

    assign rem_shift = {rem_reg, dividend_reg[ccp_pkg::DIV_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, modulus_reg};

    assign dmask = ccp_pkg::VAL_W'(pow2 - 17'd1);
    assign val   = need_div_reg ? (quot_reg[ccp_pkg::VAL_W-1:0] & dmask)
                                : ({4'b0, x_reg} & dmask);

    assign pend       = acc_reg[6:0] & 7'((8'd1 << count_reg[2:0]) - 8'd1);
    assign byte_shift = count_reg - 5'd8;
    assign byte_val   = 8'(acc_reg >> byte_shift);
    assign flush_val  = {1'b0, pend} << (4'd8 - {1'b0, count_reg[2:0]});

    assign acc_next   = ccp_pkg::ACC_W'({15'b0, pend} << bits_reg) | {6'b0, val};
    assign count_next = count_reg + {1'b0, bits_reg};

    assign status.need_div   = need_div_in;
    assign status.div_done   = step_reg == ccp_pkg::STEP_W'(ccp_pkg::DIV_W - 1);
    assign status.count_ge8  = count_reg >= 5'd8;
    assign status.count_zero = count_reg == '0;
    assign status.last       = last_reg;
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= 13'd4096;
            bits_reg      <= 4'd12;
            acc_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ccp_pkg::REG_MODULUS: modulus_reg <= cfg_data;
                    ccp_pkg::REG_BITS:    bits_reg    <= cfg_data[ccp_pkg::D_BITS-1:0];
                    default:              modulus_reg <= modulus_reg;
                endcase
            end
            if (cmd.merge)
            begin
                acc_reg   <= acc_next;
                count_reg <= count_next;
            end
            else if (cmd.emit_byte)
            begin
                count_reg <= byte_shift;
            end
            else if (cmd.emit_flush || (cmd.finish && last_reg))
            begin
                acc_reg   <= '0;
                count_reg <= '0;
            end
            if (cmd.emit_byte || cmd.emit_flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg        <= s_tdata[ccp_pkg::COEFF_BITS-1:0];
            last_reg     <= s_tlast;
            need_div_reg <= need_div_in;
            dividend_reg <= dividend_init;
            rem_reg      <= '0;
            quot_reg     <= '0;
            step_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= {dividend_reg[ccp_pkg::DIV_W-2:0], 1'b0};
            rem_reg      <= rem_ge ? ccp_pkg::MOD_BITS'(rem_shift - {1'b0, modulus_reg})
                                   : rem_shift[ccp_pkg::MOD_BITS-1:0];
            quot_reg     <= {quot_reg[ccp_pkg::DIV_W-2:0], rem_ge};
            step_reg     <= step_reg + 1'b1;
        end
        if (cmd.emit_byte)
        begin
            out_data_reg <= byte_val;
            out_last_reg <= last_reg && (count_reg == 5'd8);
        end
        else if (cmd.emit_flush)
        begin
            out_data_reg <= flush_val;
            out_last_reg <= 1'b1;
        end
    end

endmodule

/* hdl/ccp_controller.sv */
// Controller state machine that sequences load, divide, merge and byte emission.
`timescale 1ns / 1ps
`include "coefficient_compress_pack_unit_defines.svh"
module ccp_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ccp_pkg::status_t     status,
    output ccp_pkg::cmd_t        cmd
);

    ccp_pkg::state_t state_reg;
    ccp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ccp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ccp_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.need_div ? ccp_pkg::ST_DIV : ccp_pkg::ST_MERGE;
                end
            end
            ccp_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ccp_pkg::ST_MERGE;
                end
            end
            ccp_pkg::ST_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = ccp_pkg::ST_EMIT;
            end
            ccp_pkg::ST_EMIT:
            begin
                priority if (status.count_ge8)
                begin
                    cmd.emit_byte = status.out_free;
                end
                else if (status.last && !status.count_zero)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit_flush = 1'b1;
                        state_next     = ccp_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ccp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ccp_pkg::ST_IDLE;
            end
        endcase
    end

    `CCP_ASSERT_SAME(a_emit_needs_slot, cmd.emit_byte || cmd.emit_flush, status.out_free)
    `CCP_ASSERT_NEXT(a_accept_blocks, s_tvalid && s_tready, !s_tready)
    `CCP_ASSERT_NEXT(a_flush_ends_item, cmd.emit_flush, s_tready)
    `CCP_ASSERT_SAME(a_flush_only_last, cmd.emit_flush, status.last && !status.count_ge8)

endmodule

/* hdl/coefficient_compress_pack_unit.sv */
// Top level of the coefficient compress and bit pack unit.
//
//   Channel   Direction  Payload
//   s_*       in         tdata[11:0] coefficient, tlast last_coefficient
//   m_*       out        tdata[7:0] packed_byte, tlast last_byte
//   cfg_*     in         index 0 modulus, index 1 bits_per_coefficient
//
// One coefficient at a time. Accept loads the coefficient; when 2^bits is below
// the modulus, a division by the modulus follows (one quotient bit per cycle in the
// serial divider), then merge, then one emit step per full output byte (0 to 2) and
// a closing step that sends the flush byte for a last coefficient with bits left.
// A stalled output holds the emit step until the output register frees.
// Reset clears the bit accumulator and sets modulus 4096, width 12.
`timescale 1ns / 1ps
module coefficient_compress_pack_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] coefficient, [15:12] zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] packed_byte
    output logic        m_tlast
);

    ccp_pkg::cmd_t    cmd;
    ccp_pkg::status_t status;

    ccp_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ccp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
